### rtl/bsmg_pkg.sv
// Shared constants, types and state codes for the bounded set min/max gap unit.
package bsmg_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CAP_W       = 11;
  localparam int VAL_W       = 32;
  localparam int WIDE_W      = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
  localparam int PAIR_MIN    = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int OUT_DATA_W  = 80;

  localparam logic [VAL_W-1:0] SIGN_BIAS = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] GAP_INIT  = {VAL_W{1'b1}};

  localparam logic STATUS_STORED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } wr_req_t;

  // Map signed bits to an unsigned key with the same order.
  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits);
    return bits ^ SIGN_BIAS;
  endfunction

endpackage

### rtl/bounded_set_min_max_gap_unit.sv
// Bounded set of signed numbers reporting count, shortest span and longest span.
//
// Usage: write the capacity register over the APB-style port (address 0)
// while the block is idle. Offer one signed 32-bit number per item on the
// in_ stream. Each accepted item yields exactly one result item on out_:
// out_tuser is the status (stored or rejected because the store is full),
// out_tdata carries the count and both spans.
// A rejected item or the first stored item goes from idle straight to the
// done state, where its result is loaded into the output register once that
// register is free; any other stored item first passes the scan and drain
// states, since the new number is compared against every held number
// through one read port of the store and one shared difference/minimum
// unit. The block takes one item at a time.
// A finished result sits in an output register; the block accepts the next
// item while it waits, and holds a second result until the receiver takes
// the first. Reset empties the set, clears capacity to zero (every item is
// rejected until capacity is written) and sets the shortest span tracker to
// all ones. Store contents are not cleared; only written entries are read.
module bounded_set_min_max_gap_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: value[31:0]
  input  logic signed [31:0]                    in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // out_tdata: entry_count[10:0], shortest_span[42:11], longest_span[74:43], zero pad
  output logic [bsmg_pkg::OUT_DATA_W-1:0]       out_tdata,
  // out_tuser: status[0]
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [bsmg_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  bsmg_pkg::state_t              state_r, state_nxt;
  logic [bsmg_pkg::CAP_W-1:0]    capacity_r;
  logic [bsmg_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [bsmg_pkg::COUNT_W-1:0]  idx_r, idx_nxt;
  logic [bsmg_pkg::VAL_W-1:0]    value_r, value_nxt;
  logic [bsmg_pkg::VAL_W-1:0]    least_r, least_nxt;
  logic [bsmg_pkg::VAL_W-1:0]    greatest_r, greatest_nxt;
  logic                          status_r, status_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic                          out_load;
  logic [bsmg_pkg::CAP_W-1:0]    res_count;
  logic [bsmg_pkg::VAL_W-1:0]    res_short;
  logic [bsmg_pkg::VAL_W-1:0]    res_long;
  logic [bsmg_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                          out_tuser_r;

  logic [bsmg_pkg::WIDE_W-1:0]   cap_ext;
  logic [bsmg_pkg::WIDE_W-1:0]   max_ext;
  logic [bsmg_pkg::WIDE_W-1:0]   limit;
  logic [bsmg_pkg::WIDE_W-1:0]   count_ext;
  logic                          in_accept;
  logic                          cfg_write;

  bsmg_pkg::rd_req_t             rd;
  bsmg_pkg::wr_req_t             wr;
  logic [bsmg_pkg::VAL_W-1:0]    rd_data;
  logic                          rd_valid;
  logic [bsmg_pkg::VAL_W-1:0]    gap_min;
  logic                          gap_busy;

  bsmg_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .rd         (rd),
    .rd_data_r  (rd_data),
    .rd_valid_r (rd_valid)
  );

  bsmg_gap_unit u_gap (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (rd_valid),
    .cand       (rd_data),
    .probe      (value_r),
    .gap_min_r  (gap_min),
    .busy       (gap_busy)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == bsmg_pkg::REG_CAPACITY)
                      ? {{(32-bsmg_pkg::CAP_W){1'b0}}, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_write && (cfg_paddr[2] == bsmg_pkg::REG_CAPACITY)) begin
      capacity_r <= cfg_pwdata[bsmg_pkg::CAP_W-1:0];
    end
  end

  assign cap_ext   = bsmg_pkg::WIDE_W'(capacity_r);
  assign max_ext   = bsmg_pkg::WIDE_W'(bsmg_pkg::MAX_ENTRIES);
  assign limit     = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign count_ext = bsmg_pkg::WIDE_W'(count_r);

  assign in_tready = (state_r == bsmg_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Result fields from the store state after the item
  assign res_count = bsmg_pkg::CAP_W'(count_r);
  assign res_short = (count_r < bsmg_pkg::COUNT_W'(bsmg_pkg::PAIR_MIN)) ? '0 : gap_min;
  assign res_long  = (count_r < bsmg_pkg::COUNT_W'(bsmg_pkg::PAIR_MIN)) ? '0
                     : (bsmg_pkg::order_key(greatest_r) - bsmg_pkg::order_key(least_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    least_nxt      = least_r;
    greatest_nxt   = greatest_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_load       = 1'b0;
    rd             = '0;
    wr             = '0;
    wr.addr        = count_r[bsmg_pkg::IDX_W-1:0];
    wr.data        = value_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      bsmg_pkg::ST_IDLE: begin
        if (in_accept) begin
          value_nxt = in_tdata;
          if (count_ext >= limit) begin
            status_nxt = bsmg_pkg::STATUS_REJECTED;
            state_nxt  = bsmg_pkg::ST_DONE;
          end else if (count_r == '0) begin
            status_nxt   = bsmg_pkg::STATUS_STORED;
            least_nxt    = in_tdata;
            greatest_nxt = in_tdata;
            wr.en        = 1'b1;
            wr.data      = in_tdata;
            count_nxt    = count_r + 1'b1;
            state_nxt    = bsmg_pkg::ST_DONE;
          end else begin
            status_nxt = bsmg_pkg::STATUS_STORED;
            idx_nxt    = '0;
            state_nxt  = bsmg_pkg::ST_SCAN;
          end
        end
      end
      bsmg_pkg::ST_SCAN: begin
        // Issue one read per cycle over the held entries
        rd.en   = 1'b1;
        rd.addr = idx_r[bsmg_pkg::IDX_W-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == count_r) begin
          state_nxt = bsmg_pkg::ST_DRAIN;
        end
      end
      bsmg_pkg::ST_DRAIN: begin
        // Wait for the last comparison, then append the value
        if (!gap_busy) begin
          wr.en     = 1'b1;
          count_nxt = count_r + 1'b1;
          if (bsmg_pkg::order_key(value_r) < bsmg_pkg::order_key(least_r)) begin
            least_nxt = value_r;
          end
          if (bsmg_pkg::order_key(value_r) > bsmg_pkg::order_key(greatest_r)) begin
            greatest_nxt = value_r;
          end
          state_nxt = bsmg_pkg::ST_DONE;
        end
      end
      bsmg_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = bsmg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsmg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsmg_pkg::ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      least_r      <= '0;
      greatest_r   <= '0;
      status_r     <= bsmg_pkg::STATUS_STORED;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      least_r      <= least_nxt;
      greatest_r   <= greatest_nxt;
      status_r     <= status_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (out_load) begin
      out_tuser_r <= status_r;
      out_tdata_r <= {{(bsmg_pkg::OUT_DATA_W - bsmg_pkg::CAP_W - 2*bsmg_pkg::VAL_W){1'b0}},
                      res_long, res_short, res_count};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bsmg_pkg::COUNT_W'(bsmg_pkg::MAX_ENTRIES))
    else $error("held count above store depth");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("ready right after an accepted item");
  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsmg_pkg::ST_SCAN) |-> (idx_r < count_r))
    else $error("scan index past held count");
`endif

endmodule

### rtl/bsmg_store.sv
// Value store: single-port write, registered read with a valid flag.
module bsmg_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bsmg_pkg::wr_req_t                 wr,
  input  bsmg_pkg::rd_req_t                 rd,
  output logic [bsmg_pkg::VAL_W-1:0]        rd_data_r,
  output logic                              rd_valid_r
);

  logic [bsmg_pkg::VAL_W-1:0] mem [bsmg_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd.en;
    end
  end

endmodule

### rtl/bsmg_gap_unit.sv
// Shared gap unit: absolute key difference, then running minimum update.
module bsmg_gap_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cand_valid,
  input  logic [bsmg_pkg::VAL_W-1:0]        cand,
  input  logic [bsmg_pkg::VAL_W-1:0]        probe,
  output logic [bsmg_pkg::VAL_W-1:0]        gap_min_r,
  output logic                              busy
);

  logic [bsmg_pkg::VAL_W-1:0] ka;
  logic [bsmg_pkg::VAL_W-1:0] kb;
  logic [bsmg_pkg::VAL_W-1:0] diff_nxt;
  logic [bsmg_pkg::VAL_W-1:0] diff_r;
  logic                       diff_valid_r;

  assign ka       = bsmg_pkg::order_key(probe);
  assign kb       = bsmg_pkg::order_key(cand);
  assign diff_nxt = (ka > kb) ? (ka - kb) : (kb - ka);
  assign busy     = cand_valid || diff_valid_r;

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_valid_r <= 1'b0;
      gap_min_r    <= bsmg_pkg::GAP_INIT;
    end else begin
      diff_valid_r <= cand_valid;
      if (diff_valid_r && (diff_r < gap_min_r)) begin
        gap_min_r <= diff_r;
      end
    end
  end

`ifndef SYNTHESIS
  a_min_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1 |=> gap_min_r <= $past(gap_min_r))
    else $error("smallest gap increased");
`endif

endmodule
